// ----- hw/rtl/tepd_pkg.sv -----
// Shared types and constants for the touch event point decoder.
package tepd_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int AXIS_W     = 17;
    localparam int DIFF_W     = 18;
    localparam int SIZE_W     = 14;
    localparam int PROD_W     = 32;
    localparam int NUM_W      = 31;
    localparam int COORD_W    = 16;
    localparam int SLOT_NUM_W = 4;
    localparam int COLOR_W    = 24;
    localparam int CODE_W     = 6;

    localparam logic [CODE_W-1:0] CODE_X      = 6'd0;
    localparam logic [CODE_W-1:0] CODE_Y      = 6'd1;
    localparam logic [CODE_W-1:0] CODE_SLOT   = 6'd47;
    localparam logic [CODE_W-1:0] CODE_SLOT_X = 6'd53;
    localparam logic [CODE_W-1:0] CODE_SLOT_Y = 6'd54;

    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTI     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR = 3'd7;

    localparam logic signed [AXIS_W-1:0] RST_AXIS_MIN = 17'sd0;
    localparam logic signed [AXIS_W-1:0] RST_AXIS_MAX = 17'sd4095;
    localparam logic [SIZE_W-1:0]        RST_WIDTH    = 14'd1024;
    localparam logic [SIZE_W-1:0]        RST_HEIGHT   = 14'd768;
    localparam logic [COLOR_W-1:0]       RST_COLOR    = 24'hFFFFFF;

    localparam logic [COORD_W-1:0] EVEN_MASK = 16'hFFFE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SLOT_WR,
        ST_SYNC_SINGLE,
        ST_SYNC_SCAN,
        ST_SYNC_DATA
    } top_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } scale_state_t;

endpackage

// ----- hw/rtl/tepd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tepd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tepd_scale.sv -----
// Axis scaler: (value - lo) * size / (hi - lo), bit-serial signed divide.
module tepd_scale import tepd_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [AXIS_W-1:0] value,
    input  logic signed [AXIS_W-1:0] lo,
    input  logic signed [AXIS_W-1:0] hi,
    input  logic [SIZE_W-1:0]        size,
    output logic                     done,
    output logic [COORD_W-1:0]       result
);

    scale_state_t state_reg, state_next;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] rng_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [AXIS_W-1:0]        den_reg;
    logic [AXIS_W-1:0]        rem_reg;
    logic                     neg_reg;
    logic [4:0]               cnt_reg;

    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_mag;
    logic [DIFF_W-1:0]        rng_mag;
    logic                     rng_zero;
    logic [AXIS_W:0]          rem_sh;
    logic                     ge;
    logic [AXIS_W-1:0]        rem_next;

    assign prod     = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, size_reg}));
    assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign rng_mag  = rng_reg[DIFF_W-1] ? DIFF_W'(-rng_reg) : DIFF_W'(rng_reg);
    assign rng_zero = (rng_reg == '0);

    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign rem_next = ge ? AXIS_W'(rem_sh - {1'b0, den_reg}) : rem_sh[AXIS_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE: if (start) state_next = SC_MUL;
            SC_MUL:  state_next = rng_zero ? SC_DONE : SC_DIV;
            SC_DIV:  if (cnt_reg == 5'(NUM_W - 1)) state_next = SC_DONE;
            SC_DONE: state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == SC_DONE);
        result = neg_reg ? COORD_W'(16'd0 - num_reg[COORD_W-1:0]) : num_reg[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SC_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == SC_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    diff_reg <= DIFF_W'(value) - DIFF_W'(lo);
                    rng_reg  <= DIFF_W'(hi) - DIFF_W'(lo);
                    size_reg <= size;
                end
            end
            SC_MUL:
            begin
                num_reg <= rng_zero ? '0 : prod_mag[NUM_W-1:0];
                den_reg <= rng_mag[AXIS_W-1:0];
                neg_reg <= rng_zero ? 1'b0 : (prod[PROD_W-1] ^ rng_reg[DIFF_W-1]);
                rem_reg <= '0;
            end
            SC_DIV:
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[NUM_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/touch_event_point_decoder.sv -----
// Top level of the touch event point decoder.
//
// Input stream (s_axis): one touch event per request. tuser is the event
// kind (0 frame sync, 1 absolute axis report); tdata carries the axis code
// and the signed raw value. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); the user writes it only while the block is idle (not enforced).
// Output stream (m_axis): one screen point per request, coordinates rounded
// down to even, tuser set for slot points, tlast on the final point of a sync.
// Events are handled one at a time. An X or Y report goes through a
// multiply step and a restoring divide in the scaler; slot X/Y reports
// add a read-modify-write of the slot RAM. Slot select and ignored
// reports finish in the idle state. A sync passes the single-point state,
// then takes a data step per updated slot and a scan step per skipped slot
// below the highest updated one. Points leave through an output register;
// the block keeps taking events while the last point of a sync waits
// there. A stalled receiver holds the sync walk until the register frees.
// Reset restores the register defaults and clears all touch state; slot RAM
// entries read as zero until first written (one valid bit per slot).
module touch_event_point_decoder import tepd_pkg::*; #(
    parameter int SLOT_COUNT = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // axis_code[5:0], event_value[22:6]
    input  logic [0:0]             s_axis_tuser,   // func[0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // point_x, point_y, slot_number, point_color
    output logic [0:0]             m_axis_tuser,   // from_slot[0]
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RAM_W  = 2 * COORD_W;

    top_state_t state_reg, state_next;

    logic signed [AXIS_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [SIZE_W-1:0]        width_reg, height_reg;
    logic                     multi_reg;
    logic [COLOR_W-1:0]       pen_reg;

    logic [COORD_W-1:0]       single_x_reg, single_y_reg;
    logic                     single_pending_reg;
    logic                     sel_valid_reg;
    logic [SLOT_W-1:0]        sel_reg;
    logic [SLOT_COUNT-1:0]    mask_reg;
    logic [SLOT_COUNT-1:0]    valid_reg;
    logic [SLOT_W-1:0]        scan_idx_reg;
    logic                     is_y_reg;
    logic                     is_slot_reg;
    logic [COORD_W-1:0]       res_reg;
    logic                     rd_valid_reg;

    logic                     m_valid_reg;
    logic [COORD_W-1:0]       out_x_reg, out_y_reg;
    logic                     out_from_reg;
    logic [SLOT_NUM_W-1:0]    out_slot_reg;
    logic [COLOR_W-1:0]       out_color_reg;
    logic                     out_last_reg;

    logic                     in_accept;
    logic                     in_func;
    logic [CODE_W-1:0]        in_code;
    logic signed [AXIS_W-1:0] in_value;
    logic                     in_is_y;
    logic                     in_is_single;
    logic                     in_is_slot_axis;
    logic                     in_scale;
    logic                     sel_in_range;

    logic                     out_free;
    logic                     single_need;
    logic [SLOT_COUNT-1:0]    scan_bit;
    logic                     slot_last;
    logic                     scale_start;
    logic                     scale_done;
    logic [COORD_W-1:0]       scale_result;
    logic                     ram_we;
    logic                     ram_re;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [RAM_W-1:0]         ram_wdata;
    logic [RAM_W-1:0]         ram_rdata;
    logic [RAM_W-1:0]         ram_old;
    logic                     out_load_single;
    logic                     out_load_slot;
    logic                     sync_done;

    assign in_accept       = s_axis_tvalid & s_axis_tready;
    assign in_func         = s_axis_tuser[0];
    assign in_code         = s_axis_tdata[CODE_W-1:0];
    assign in_value        = $signed(s_axis_tdata[CODE_W+AXIS_W-1:CODE_W]);
    assign in_is_y         = (in_code == CODE_Y) || (in_code == CODE_SLOT_Y);
    assign in_is_single    = (in_code == CODE_X) || (in_code == CODE_Y);
    assign in_is_slot_axis = (in_code == CODE_SLOT_X) || (in_code == CODE_SLOT_Y);
    assign in_scale        = in_is_single || (in_is_slot_axis && multi_reg && sel_valid_reg);
    assign sel_in_range    = !in_value[AXIS_W-1]
                             && (in_value[COORD_W-1:0] < COORD_W'(SLOT_COUNT));

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign single_need = single_pending_reg && ((mask_reg == '0) || !multi_reg);
    assign scan_bit    = SLOT_COUNT'(1) << scan_idx_reg;
    assign slot_last   = ((mask_reg & ~scan_bit) == '0);
    assign ram_old     = rd_valid_reg ? ram_rdata : '0;
    assign ram_wdata   = is_y_reg ? {res_reg, ram_old[COORD_W-1:0]}
                                  : {ram_old[RAM_W-1:COORD_W], res_reg};

    tepd_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .value  (in_value),
        .lo     (in_is_y ? y_min_reg : x_min_reg),
        .hi     (in_is_y ? y_max_reg : x_max_reg),
        .size   (in_is_y ? height_reg : width_reg),
        .done   (scale_done),
        .result (scale_result)
    );

    tepd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sel_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_func)
                    begin
                        state_next = ST_SYNC_SINGLE;
                    end
                    else if (in_scale)
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = is_slot_reg ? ST_SLOT_WR : ST_IDLE;
                end
            end
            ST_SLOT_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_SYNC_SINGLE:
            begin
                if (!single_need || out_free)
                begin
                    state_next = ST_SYNC_SCAN;
                end
            end
            ST_SYNC_SCAN:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (mask_reg[scan_idx_reg])
                begin
                    state_next = ST_SYNC_DATA;
                end
            end
            ST_SYNC_DATA:
            begin
                if (out_free)
                begin
                    state_next = ST_SYNC_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE);
        scale_start     = (state_reg == ST_IDLE) && in_accept && in_func && in_scale;
        ram_re          = ((state_reg == ST_SCALE) && scale_done && is_slot_reg)
                          || ((state_reg == ST_SYNC_SCAN) && mask_reg[scan_idx_reg]);
        ram_raddr       = (state_reg == ST_SYNC_SCAN) ? scan_idx_reg : sel_reg;
        ram_we          = (state_reg == ST_SLOT_WR);
        out_load_single = (state_reg == ST_SYNC_SINGLE) && single_need && out_free;
        out_load_slot   = (state_reg == ST_SYNC_DATA) && out_free;
        sync_done       = (state_reg == ST_SYNC_SCAN) && (mask_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            x_min_reg          <= RST_AXIS_MIN;
            x_max_reg          <= RST_AXIS_MAX;
            y_min_reg          <= RST_AXIS_MIN;
            y_max_reg          <= RST_AXIS_MAX;
            width_reg          <= RST_WIDTH;
            height_reg         <= RST_HEIGHT;
            multi_reg          <= 1'b0;
            pen_reg            <= RST_COLOR;
            single_x_reg       <= '0;
            single_y_reg       <= '0;
            single_pending_reg <= 1'b0;
            sel_valid_reg      <= 1'b0;
            sel_reg            <= '0;
            mask_reg           <= '0;
            valid_reg          <= '0;
            scan_idx_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_MIN:     x_min_reg  <= $signed(cfg_data[AXIS_W-1:0]);
                    CFG_X_MAX:     x_max_reg  <= $signed(cfg_data[AXIS_W-1:0]);
                    CFG_Y_MIN:     y_min_reg  <= $signed(cfg_data[AXIS_W-1:0]);
                    CFG_Y_MAX:     y_max_reg  <= $signed(cfg_data[AXIS_W-1:0]);
                    CFG_WIDTH:     width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:    height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_MULTI:     multi_reg  <= cfg_data[0];
                    CFG_PEN_COLOR: pen_reg    <= cfg_data[COLOR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if ((state_reg == ST_IDLE) && in_accept)
            begin
                scan_idx_reg <= '0;
                if (in_func && (in_code == CODE_SLOT))
                begin
                    sel_valid_reg <= sel_in_range;
                    if (sel_in_range)
                    begin
                        sel_reg <= in_value[SLOT_W-1:0];
                    end
                end
            end

            if ((state_reg == ST_SCALE) && scale_done && !is_slot_reg)
            begin
                single_pending_reg <= 1'b1;
                if (is_y_reg)
                begin
                    single_y_reg <= scale_result;
                end
                else
                begin
                    single_x_reg <= scale_result;
                end
            end

            if (ram_we)
            begin
                mask_reg[sel_reg]  <= 1'b1;
                valid_reg[sel_reg] <= 1'b1;
            end

            if (out_load_slot)
            begin
                mask_reg     <= mask_reg & ~scan_bit;
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
            else if ((state_reg == ST_SYNC_SCAN) && !mask_reg[scan_idx_reg])
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end

            if (sync_done)
            begin
                single_pending_reg <= 1'b0;
                sel_valid_reg      <= 1'b0;
                mask_reg           <= '0;
            end

            if (out_load_single || out_load_slot)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_accept)
        begin
            is_y_reg    <= in_is_y;
            is_slot_reg <= in_is_slot_axis;
        end
        if (scale_done)
        begin
            res_reg <= scale_result;
        end
        if (ram_re)
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end
        if (out_load_single)
        begin
            out_x_reg     <= single_x_reg & EVEN_MASK;
            out_y_reg     <= single_y_reg & EVEN_MASK;
            out_from_reg  <= 1'b0;
            out_slot_reg  <= '0;
            out_color_reg <= pen_reg;
            out_last_reg  <= (mask_reg == '0);
        end
        else if (out_load_slot)
        begin
            out_x_reg     <= ram_old[COORD_W-1:0] & EVEN_MASK;
            out_y_reg     <= ram_old[RAM_W-1:COORD_W] & EVEN_MASK;
            out_from_reg  <= 1'b1;
            out_slot_reg  <= SLOT_NUM_W'(scan_idx_reg);
            out_color_reg <= pen_reg;
            out_last_reg  <= slot_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, out_color_reg, out_slot_reg, out_y_reg, out_x_reg};
    assign m_axis_tuser  = out_from_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load_single || out_load_slot) |-> (!m_valid_reg || m_axis_tready))
        else $error("point loaded over an unaccepted point");

    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("slot RAM read and written in the same cycle");

    a_mask_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg & ~valid_reg) == '0)
        else $error("updated slot without a written entry");

    a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
        sync_done |=> (state_reg == ST_IDLE && !single_pending_reg && !sel_valid_reg))
        else $error("sync did not clear pending state");
`endif

endmodule

// ----- tb/tb_touch_event_point_decoder.sv -----
// Self-checking testbench for the touch event point decoder: event stream in, checked points out.
module tb_touch_event_point_decoder;
    import tepd_pkg::*;

    localparam int SLOT_COUNT     = 10;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_EVENTS   = 80;

    localparam logic [CODE_W-1:0] CODE_UNUSED_LO = 6'd2;
    localparam logic [CODE_W-1:0] CODE_UNUSED_HI = 6'd63;

    typedef enum logic {
        EV_SYNC = 1'b0,
        EV_AXIS = 1'b1
    } event_kind_t;

    typedef struct packed {
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic                  from_slot;
        logic [SLOT_NUM_W-1:0] slot;
        logic [COLOR_W-1:0]    color;
        logic                  last;
    } touch_point_t;

    class point_predictor;
        logic signed [AXIS_W-1:0] x_min, x_max, y_min, y_max;
        logic [SIZE_W-1:0]        width, height;
        logic                     multitouch;
        logic [COLOR_W-1:0]       color;
        logic [COORD_W-1:0]       single_x, single_y;
        logic                     single_pending;
        logic                     sel_valid;
        logic [SLOT_NUM_W-1:0]    sel;
        logic [COORD_W-1:0]       slot_x [SLOT_COUNT];
        logic [COORD_W-1:0]       slot_y [SLOT_COUNT];
        logic [SLOT_COUNT-1:0]    updated;
        touch_point_t             expected_points[$];
        int                       mismatches;

        function new();
            x_min = RST_AXIS_MIN;
            x_max = RST_AXIS_MAX;
            y_min = RST_AXIS_MIN;
            y_max = RST_AXIS_MAX;
            width = RST_WIDTH;
            height = RST_HEIGHT;
            multitouch = 1'b0;
            color = RST_COLOR;
            single_x = '0;
            single_y = '0;
            single_pending = 1'b0;
            sel_valid = 1'b0;
            sel = '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_x[i] = '0;
                slot_y[i] = '0;
            end
            updated = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_X_MIN:     x_min = d[AXIS_W-1:0];
                CFG_X_MAX:     x_max = d[AXIS_W-1:0];
                CFG_Y_MIN:     y_min = d[AXIS_W-1:0];
                CFG_Y_MAX:     y_max = d[AXIS_W-1:0];
                CFG_WIDTH:     width = d[SIZE_W-1:0];
                CFG_HEIGHT:    height = d[SIZE_W-1:0];
                CFG_MULTI:     multitouch = d[0];
                CFG_PEN_COLOR: color = d[COLOR_W-1:0];
                default:       ;
            endcase
        endfunction

        function logic [COORD_W-1:0] scale(logic signed [AXIS_W-1:0] v,
                                           logic signed [AXIS_W-1:0] lo,
                                           logic signed [AXIS_W-1:0] hi,
                                           logic [SIZE_W-1:0] sz);
            longint span;
            longint q;
            span = longint'(hi) - longint'(lo);
            if (span == 0)
                return '0;
            q = ((longint'(v) - longint'(lo)) * longint'(sz)) / span;
            return q[COORD_W-1:0];
        endfunction

        function touch_point_t make_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                          logic fs, logic [SLOT_NUM_W-1:0] sn);
            touch_point_t p;
            p.x = px & EVEN_MASK;
            p.y = py & EVEN_MASK;
            p.from_slot = fs;
            p.slot = sn;
            p.color = color;
            p.last = 1'b0;
            return p;
        endfunction

        function void note_event(event_kind_t kind, logic [CODE_W-1:0] code,
                                 logic signed [AXIS_W-1:0] v);
            int first;
            if (kind == EV_SYNC)
            begin
                first = expected_points.size();
                if (single_pending && (updated == '0 || !multitouch))
                    expected_points.push_back(make_point(single_x, single_y, 1'b0, '0));
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (updated[i])
                        expected_points.push_back(make_point(slot_x[i], slot_y[i], 1'b1,
                                                             SLOT_NUM_W'(i)));
                if (expected_points.size() > first)
                    expected_points[expected_points.size()-1].last = 1'b1;
                single_pending = 1'b0;
                sel_valid = 1'b0;
                updated = '0;
                return;
            end
            case (code)
                CODE_X:
                begin
                    single_x = scale(v, x_min, x_max, width);
                    single_pending = 1'b1;
                end
                CODE_Y:
                begin
                    single_y = scale(v, y_min, y_max, height);
                    single_pending = 1'b1;
                end
                CODE_SLOT:
                begin
                    if (v >= 0 && v < SLOT_COUNT)
                    begin
                        sel_valid = 1'b1;
                        sel = v[SLOT_NUM_W-1:0];
                    end
                    else
                        sel_valid = 1'b0;
                end
                CODE_SLOT_X, CODE_SLOT_Y:
                begin
                    if (multitouch && sel_valid)
                    begin
                        if (code == CODE_SLOT_X)
                            slot_x[sel] = scale(v, x_min, x_max, width);
                        else
                            slot_y[sel] = scale(v, y_min, y_max, height);
                        updated[sel] = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s expected %0h got %0h", $time, field, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_point(touch_point_t got);
            touch_point_t exp_p;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point expected none got %0h", $time, got);
                mismatches++;
                return;
            end
            exp_p = expected_points.pop_front();
            report("point_x", exp_p.x, got.x);
            report("point_y", exp_p.y, got.y);
            report("from_slot", exp_p.from_slot, got.from_slot);
            report("slot_number", exp_p.slot, got.slot);
            report("point_color", exp_p.color, got.color);
            report("last", exp_p.last, got.last);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    point_predictor sb = new();
    int  events_sent = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;

    always #5 clk = ~clk;

    touch_event_point_decoder #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [AXIS_W-1:0] rand_axis(logic signed [AXIS_W-1:0] lo,
                                                           logic signed [AXIS_W-1:0] hi);
        int a;
        int b;
        int t;
        a = lo;
        b = hi;
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        if ($urandom_range(0, 9) < 8)
            return AXIS_W'(a + int'($urandom_range(0, b - a)));
        return AXIS_W'($urandom);
    endfunction

    // output side: random back-pressure, point check, watchdog
    initial
    begin : rx_side
        int stall;
        int quiet;
        touch_point_t got;
        stall = 0;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x = m_axis_tdata[15:0];
                got.y = m_axis_tdata[31:16];
                got.slot = m_axis_tdata[35:32];
                got.color = m_axis_tdata[59:36];
                got.from_slot = m_axis_tuser[0];
                got.last = m_axis_tlast;
                sb.check_point(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("touch_event_point_decoder regression: fail");
                $finish;
            end
            if (stall == 0 && rx_stalls_on && $urandom_range(0, 2) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_event(event_kind_t kind, logic [CODE_W-1:0] code,
                              logic signed [AXIS_W-1:0] v);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, v, code};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_event(kind, code, v);
        events_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic signed [AXIS_W-1:0] xlo, logic signed [AXIS_W-1:0] xhi,
                             logic signed [AXIS_W-1:0] ylo, logic signed [AXIS_W-1:0] yhi,
                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic mt,
                             logic [COLOR_W-1:0] col);
        logic [CFG_DATA_W-1:0] regs [8];
        regs[CFG_X_MIN] = CFG_DATA_W'(unsigned'(xlo));
        regs[CFG_X_MAX] = CFG_DATA_W'(unsigned'(xhi));
        regs[CFG_Y_MIN] = CFG_DATA_W'(unsigned'(ylo));
        regs[CFG_Y_MAX] = CFG_DATA_W'(unsigned'(yhi));
        regs[CFG_WIDTH] = CFG_DATA_W'(w);
        regs[CFG_HEIGHT] = CFG_DATA_W'(h);
        regs[CFG_MULTI] = CFG_DATA_W'(mt);
        regs[CFG_PEN_COLOR] = col;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= regs[i];
            sb.set_reg(CFG_IDX_W'(i), regs[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // one touch frame: slot contacts and/or single touch, some noise, then a sync most of the time
    task automatic random_frame();
        int nslots;
        int slot;
        logic signed [AXIS_W-1:0] bad;
        nslots = 0;
        if (sb.multitouch && $urandom_range(0, 9) < 7)
            nslots = ($urandom_range(0, 9) == 0) ? SLOT_COUNT : $urandom_range(1, 4);
        for (int k = 0; k < nslots; k++)
        begin
            slot = (nslots == SLOT_COUNT) ? k : $urandom_range(0, SLOT_COUNT - 1);
            send_event(EV_AXIS, CODE_SLOT, AXIS_W'(slot));
            if ($urandom_range(0, 3) != 0)
                send_event(EV_AXIS, CODE_SLOT_X, rand_axis(sb.x_min, sb.x_max));
            if ($urandom_range(0, 3) != 0)
                send_event(EV_AXIS, CODE_SLOT_Y, rand_axis(sb.y_min, sb.y_max));
        end
        if (nslots == 0 || $urandom_range(0, 2) == 0)
        begin
            if ($urandom_range(0, 4) != 0)
                send_event(EV_AXIS, CODE_X, rand_axis(sb.x_min, sb.x_max));
            if ($urandom_range(0, 4) != 0)
                send_event(EV_AXIS, CODE_Y, rand_axis(sb.y_min, sb.y_max));
        end
        if ($urandom_range(0, 4) == 0)
            send_event(event_kind_t'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 63)),
                       AXIS_W'($urandom));
        if ($urandom_range(0, 7) == 0)
        begin
            // rejected slot select, then a slot report that must be dropped
            case ($urandom_range(0, 2))
                0:       bad = AXIS_W'($urandom_range(SLOT_COUNT, 15));
                1:       bad = -AXIS_W'($urandom_range(1, 65536));
                default: bad = AXIS_W'($urandom_range(16, 65535));
            endcase
            send_event(EV_AXIS, CODE_SLOT, bad);
            send_event(EV_AXIS, CODE_SLOT_X, rand_axis(sb.x_min, sb.x_max));
        end
        if ($urandom_range(0, 9) != 0)
            send_event(EV_SYNC, CODE_X, AXIS_W'($urandom));
    endtask

    initial
    begin : stimulus
        int target;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: single touch, empty sync, wrap, ignored reports
        send_event(EV_AXIS, CODE_X, 0);
        send_event(EV_AXIS, CODE_Y, 4095);
        send_event(EV_SYNC, CODE_X, 0);
        send_event(EV_SYNC, CODE_UNUSED_HI, -1);
        send_event(EV_AXIS, CODE_X, 17'h10000);
        send_event(EV_AXIS, CODE_Y, 65535);
        send_event(EV_AXIS, CODE_SLOT_X, 100);
        send_event(EV_AXIS, CODE_UNUSED_HI, -1);
        send_event(EV_AXIS, CODE_UNUSED_LO, 5);
        send_event(EV_SYNC, CODE_X, 0);
        wait_idle();

        // multitouch, full-span X, zero-range Y
        configure(17'h10000, 65535, 1234, 1234, 14'd8192, 14'd1, 1'b1, 24'h000000);
        send_event(EV_AXIS, CODE_SLOT, 9);
        send_event(EV_AXIS, CODE_SLOT_X, 65535);
        send_event(EV_AXIS, CODE_SLOT_Y, 17'h10000);
        send_event(EV_AXIS, CODE_SLOT, 10);
        send_event(EV_AXIS, CODE_SLOT_X, 5);
        send_event(EV_AXIS, CODE_SLOT, -1);
        send_event(EV_AXIS, CODE_SLOT_Y, 5);
        send_event(EV_AXIS, CODE_SLOT, 65535);
        send_event(EV_AXIS, CODE_SLOT, 0);
        send_event(EV_AXIS, CODE_SLOT_X, 17'h10000);
        send_event(EV_AXIS, CODE_X, 0);
        send_event(EV_SYNC, CODE_X, 0);
        send_event(EV_AXIS, CODE_X, 12);
        send_event(EV_SYNC, CODE_X, 0);
        send_event(EV_AXIS, CODE_SLOT, 3);
        send_event(EV_AXIS, CODE_SLOT_X, 7);
        send_event(EV_SYNC, CODE_X, 0);
        send_event(EV_AXIS, CODE_SLOT_Y, 7);
        send_event(EV_SYNC, CODE_X, 0);

        target = events_sent;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            case (phase)
                0: configure(0, 4095, 0, 4095, 14'd1024, 14'd768, 1'b0, 24'hFFFFFF);
                1: configure(0, 4095, 0, 4095, 14'd800, 14'd480, 1'b1, COLOR_W'($urandom));
                2: configure(17'h10000, 65535, 17'h10000, 65535, 14'd8192, 14'd8192, 1'b1,
                             24'hFFFFFF);
                3: configure(4095, 0, 1000, -1000, 14'd1, 14'd8192, 1'b1, 24'h000000);
                4: configure(500, 500, -20, 300, 14'd8192, 14'd1, 1'b1, COLOR_W'($urandom));
                default: configure(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                                   AXIS_W'($urandom), SIZE_W'($urandom_range(1, 8192)),
                                   SIZE_W'($urandom_range(1, 8192)), 1'($urandom),
                                   COLOR_W'($urandom));
            endcase
            tx_gaps_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_stalls_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            target += PHASE_EVENTS;
            while (events_sent < target)
                random_frame();
        end

        wait_idle();
        if (sb.pending() != 0)
        begin
            $display("%0t: points left over expected 0 got %0d", $time, sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("touch_event_point_decoder regression: pass");
        else
            $display("touch_event_point_decoder regression: fail");
        $finish;
    end

endmodule
